// ===== hdl/owm_pkg.sv =====
// Package of the omni wheel mixer: payload words, configuration record,
// the item that travels between the pipeline modules, and shared widths.
// No dependencies.
package owm_pkg;

  localparam int FracBitsDef = 16;
  localparam int CfgW        = 31;
  localparam int DataW       = 32;
  localparam int MagW        = 63;
  localparam int QuotW       = 32;
  localparam int NumLanes    = 4;
  localparam int AddrW       = 4;

  localparam logic [MagW-1:0] MagCap = MagW'(1) << (MagW - 1);

  typedef enum logic [1:0] {
    RegWheelGain = 2'd0,
    RegArmLen    = 2'd1,
    RegMaxSpeed  = 2'd2,
    RegFullPower = 2'd3
  } owm_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] linear_x;
    logic signed [DataW-1:0] linear_y;
    logic signed [DataW-1:0] angular_z;
    logic                    velocity_valid;
    logic signed [DataW-1:0] power_limit;
    logic                    power_valid;
  } owm_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] wheel_speed_a;
    logic signed [DataW-1:0] wheel_speed_b;
    logic signed [DataW-1:0] wheel_speed_c;
    logic signed [DataW-1:0] wheel_speed_d;
  } owm_out_t;

  typedef struct packed {
    logic [CfgW-1:0] wheel_gain;
    logic [CfgW-1:0] arm_len;
    logic [CfgW-1:0] max_wheel_speed;
    logic [CfgW-1:0] full_speed_power;
  } owm_cfg_t;

  typedef struct packed {
    logic [NumLanes-1:0][MagW-1:0] mag;
    logic [NumLanes-1:0]           neg;
    logic [MagW-1:0]               largest;
    logic                          max_scale;
    logic                          pwr_zero;
    logic                          pwr_scale;
    logic [CfgW-1:0]               pw;
  } owm_item_t;

endpackage

// ===== hdl/owm_regs.sv =====
// Configuration registers of the omni wheel mixer behind an APB-style port.
// Depends on owm_pkg.
module owm_regs #(
  parameter int FRAC_BITS = owm_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owm_pkg::AddrW-1:0]   paddr,
  input  logic [owm_pkg::DataW-1:0]   pwdata,
  output logic [owm_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output owm_pkg::owm_cfg_t           cfg_o
);

  owm_pkg::owm_cfg_t cfg_q, cfg_d;
  logic              wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (owm_pkg::owm_reg_e'(paddr[owm_pkg::AddrW-1:2]))
        owm_pkg::RegWheelGain: cfg_d.wheel_gain       = pwdata[owm_pkg::CfgW-1:0];
        owm_pkg::RegArmLen:    cfg_d.arm_len          = pwdata[owm_pkg::CfgW-1:0];
        owm_pkg::RegMaxSpeed:  cfg_d.max_wheel_speed  = pwdata[owm_pkg::CfgW-1:0];
        owm_pkg::RegFullPower: cfg_d.full_speed_power = pwdata[owm_pkg::CfgW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (owm_pkg::owm_reg_e'(paddr[owm_pkg::AddrW-1:2]))
      owm_pkg::RegWheelGain: prdata = owm_pkg::DataW'(cfg_q.wheel_gain);
      owm_pkg::RegArmLen:    prdata = owm_pkg::DataW'(cfg_q.arm_len);
      owm_pkg::RegMaxSpeed:  prdata = owm_pkg::DataW'(cfg_q.max_wheel_speed);
      owm_pkg::RegFullPower: prdata = owm_pkg::DataW'(cfg_q.full_speed_power);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_gain       <= owm_pkg::CfgW'(1) << FRAC_BITS;
      cfg_q.arm_len          <= '0;
      cfg_q.max_wheel_speed  <= '0;
      cfg_q.full_speed_power <= owm_pkg::CfgW'(1) << FRAC_BITS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/owm_kin.sv =====
// Inverse kinematics pipeline of the omni wheel mixer: wheel magnitudes,
// signs, largest magnitude and the limit flags, in seven stages.
// Depends on owm_pkg.
module owm_kin #(
  parameter int FRAC_BITS = owm_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  owm_pkg::owm_in_t   in_word_i,
  input  owm_pkg::owm_cfg_t  cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output owm_pkg::owm_item_t out_item_o
);

  localparam int NS  = 7;
  localparam int NL  = owm_pkg::NumLanes;
  localparam int DW  = owm_pkg::DataW;
  localparam int MW  = owm_pkg::MagW;
  localparam int CW  = owm_pkg::CfgW;
  localparam int SW  = 2 * DW;
  localparam int RW  = SW - FRAC_BITS;
  localparam int PHW = MW - FRAC_BITS;
  localparam int TW  = 3 * DW;
  localparam logic [NL-1:0] NegX = 4'b0011;
  localparam logic [NL-1:0] NegY = 4'b0110;
  localparam logic [SW-1:0] HalfRnd = SW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic                 vv;
    logic signed [DW-1:0] pw;
    logic                 pv;
    logic [NL-1:0]        neg;
  } kin_side_t;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  kin_side_t side_q [NS-1];
  kin_side_t side0_d;
  kin_side_t side2_d;

  logic signed [DW+1:0] lin_q [NL];
  logic signed [DW+1:0] lin_d [NL];
  logic signed [SW-1:0] lwz_q, lwz_d;
  logic signed [DW-1:0] larm;
  logic signed [SW-1:0] sum_q [NL];
  logic signed [SW-1:0] sum_d [NL];
  logic [RW-1:0]        m_q [NL];
  logic [RW-1:0]        m_d [NL];
  logic [NL-1:0]        neg_d;
  logic [PHW-1:0]       ph_q [NL];
  logic [PHW-1:0]       ph_d [NL];
  logic [MW-1:0]        pl_q [NL];
  logic [MW-1:0]        pl_d [NL];
  logic [NL-1:0][MW-1:0] mag4_q, mag4_d, mag5_q;
  logic [MW-1:0]        mx_q [2];
  logic [MW-1:0]        mx_d [2];
  owm_pkg::owm_item_t   item_q, item_d;

  assign rdy[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign v_d         = {v_q[NS-2:0], in_valid_i};
  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign larm = signed'({1'b0, cfg_i.arm_len});

  always_comb begin
    logic signed [DW+1:0] x;
    logic signed [DW+1:0] y;
    x = (DW+2)'(in_word_i.linear_x);
    y = (DW+2)'(in_word_i.linear_y);
    for (int k = 0; k < NL; k++) begin
      lin_d[k] = (NegX[k] ? -x : x) + (NegY[k] ? -y : y);
    end
    lwz_d = larm * in_word_i.angular_z;
    side0_d.vv  = in_word_i.velocity_valid;
    side0_d.pw  = in_word_i.power_limit;
    side0_d.pv  = in_word_i.power_valid;
    side0_d.neg = '0;
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      sum_d[k] = (SW'(lin_q[k]) <<< FRAC_BITS) + lwz_q;
    end
  end

  always_comb begin
    logic [SW-1:0] a;
    a = '0;
    for (int k = 0; k < NL; k++) begin
      if (sum_q[k][SW-1]) begin
        a = $unsigned(~sum_q[k]) + HalfRnd + SW'(1);
      end else begin
        a = $unsigned(sum_q[k]) + HalfRnd;
      end
      m_d[k]   = a[SW-1:FRAC_BITS];
      neg_d[k] = !sum_q[k][SW-1] && (sum_q[k] != '0);
    end
    side2_d     = side_q[1];
    side2_d.neg = neg_d;
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      ph_d[k] = m_q[k][RW-1:DW] * cfg_i.wheel_gain;
      pl_d[k] = m_q[k][DW-1:0] * cfg_i.wheel_gain;
    end
  end

  always_comb begin
    logic [TW-1:0] t;
    logic [TW-1:0] r;
    t = '0;
    r = '0;
    for (int k = 0; k < NL; k++) begin
      t = (TW'(ph_q[k]) << DW) + TW'(pl_q[k]) + TW'(HalfRnd);
      r = t >> FRAC_BITS;
      mag4_d[k] = (r > TW'(owm_pkg::MagCap)) ? owm_pkg::MagCap : r[MW-1:0];
    end
  end

  always_comb begin
    mx_d[0] = (mag4_q[0] > mag4_q[1]) ? mag4_q[0] : mag4_q[1];
    mx_d[1] = (mag4_q[2] > mag4_q[3]) ? mag4_q[2] : mag4_q[3];
  end

  always_comb begin
    kin_side_t s;
    s = side_q[NS-2];
    item_d.mag       = mag5_q;
    item_d.largest   = (mx_q[0] > mx_q[1]) ? mx_q[0] : mx_q[1];
    item_d.neg       = s.vv ? s.neg : '0;
    item_d.max_scale = (cfg_i.max_wheel_speed != '0) &&
                       (item_d.largest > MW'(cfg_i.max_wheel_speed));
    item_d.pwr_zero  = !s.vv || !s.pv || s.pw[DW-1] || (s.pw == '0);
    item_d.pw        = s.pw[CW-1:0];
    item_d.pwr_scale = (cfg_i.full_speed_power != '0) &&
                       (s.pw[CW-1:0] < cfg_i.full_speed_power);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      lin_q     <= lin_d;
      lwz_q     <= lwz_d;
      side_q[0] <= side0_d;
    end
    if (rdy[1]) begin
      sum_q     <= sum_d;
      side_q[1] <= side_q[0];
    end
    if (rdy[2]) begin
      m_q       <= m_d;
      side_q[2] <= side2_d;
    end
    if (rdy[3]) begin
      ph_q      <= ph_d;
      pl_q      <= pl_d;
      side_q[3] <= side_q[2];
    end
    if (rdy[4]) begin
      mag4_q    <= mag4_d;
      side_q[4] <= side_q[3];
    end
    if (rdy[5]) begin
      mag5_q    <= mag4_q;
      mx_q      <= mx_d;
      side_q[5] <= side_q[4];
    end
    if (rdy[6]) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/owm_scale.sv =====
// Pipelined proportional scaling of the four wheel magnitudes, when enabled, by a ratio
// b/d, rounded half up, with a one-bit-per-stage restoring divider per lane.
// Depends on owm_pkg.
module owm_scale #(
  parameter bit USE_POWER = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  owm_pkg::owm_item_t in_item_i,
  input  owm_pkg::owm_cfg_t  cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output owm_pkg::owm_item_t out_item_o
);

  localparam int NL     = owm_pkg::NumLanes;
  localparam int MW     = owm_pkg::MagW;
  localparam int CW     = owm_pkg::CfgW;
  localparam int QW     = owm_pkg::QuotW;
  localparam int SplitW = 32;
  localparam int NW     = MW + CW;
  localparam int NS     = QW + 3;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  logic [CW-1:0] b_w;
  logic [MW-1:0] d_w;
  logic          en_w;

  owm_pkg::owm_item_t          item_p_q, item_n_q;
  logic [NL-1:0][MW-1:0]       pl_q, pl_d;
  logic [NL-1:0][MW-SplitW+CW-1:0] ph_q, ph_d;
  logic [MW-1:0]               d_p_q, d_n_q;
  logic                        en_p_q, en_n_q;
  logic [NL-1:0][NW-1:0]       num_q, num_d;

  owm_pkg::owm_item_t    item_q [QW+1];
  logic [MW-1:0]         d_q    [QW+1];
  logic                  en_q   [QW+1];
  logic [NL-1:0][MW-1:0] rem_q  [QW+1];
  logic [NL-1:0][QW-1:0] lo_q   [QW+1];
  logic [NL-1:0][QW-1:0] q_q    [QW+1];
  logic [NL-1:0]         ovf_q  [QW+1];

  logic [NL-1:0][MW-1:0] rem0_d;
  logic [NL-1:0][QW-1:0] lo0_d;
  logic [NL-1:0]         ovf0_d;

  assign rdy[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign v_d         = {v_q[NS-2:0], in_valid_i};
  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_comb begin
    if (USE_POWER) begin
      b_w  = in_item_i.pw;
      d_w  = MW'(cfg_i.full_speed_power);
      en_w = in_item_i.pwr_scale && !in_item_i.pwr_zero;
    end else begin
      b_w  = cfg_i.max_wheel_speed;
      d_w  = in_item_i.largest;
      en_w = in_item_i.max_scale;
    end
    for (int k = 0; k < NL; k++) begin
      pl_d[k] = in_item_i.mag[k][SplitW-1:0] * b_w;
      ph_d[k] = in_item_i.mag[k][MW-1:SplitW] * b_w;
    end
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      num_d[k] = (NW'(ph_q[k]) << SplitW) + NW'(pl_q[k]) + NW'(d_p_q >> 1);
    end
  end

  always_comb begin
    logic [MW-1:0] hi;
    hi = '0;
    for (int k = 0; k < NL; k++) begin
      hi        = MW'(num_q[k][NW-1:QW]);
      ovf0_d[k] = hi >= d_n_q;
      rem0_d[k] = ovf0_d[k] ? '0 : hi;
      lo0_d[k]  = num_q[k][QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      item_p_q <= in_item_i;
      pl_q     <= pl_d;
      ph_q     <= ph_d;
      d_p_q    <= d_w;
      en_p_q   <= en_w;
    end
    if (rdy[1]) begin
      item_n_q <= item_p_q;
      num_q    <= num_d;
      d_n_q    <= d_p_q;
      en_n_q   <= en_p_q;
    end
    if (rdy[2]) begin
      item_q[0] <= item_n_q;
      d_q[0]    <= d_n_q;
      en_q[0]   <= en_n_q;
      rem_q[0]  <= rem0_d;
      lo_q[0]   <= lo0_d;
      q_q[0]    <= '0;
      ovf_q[0]  <= ovf0_d;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [NL-1:0][MW-1:0] rem_d;
    logic [NL-1:0][QW-1:0] lo_d;
    logic [NL-1:0][QW-1:0] q_d;

    always_comb begin
      logic [MW:0] rem2;
      logic [MW:0] diff;
      logic        ge;
      rem2 = '0;
      diff = '0;
      ge   = 1'b0;
      for (int k = 0; k < NL; k++) begin
        rem2     = {rem_q[j-1][k], lo_q[j-1][k][QW-1]};
        diff     = rem2 - {1'b0, d_q[j-1]};
        ge       = rem2 >= {1'b0, d_q[j-1]};
        rem_d[k] = ge ? diff[MW-1:0] : rem2[MW-1:0];
        lo_d[k]  = {lo_q[j-1][k][QW-2:0], 1'b0};
        q_d[k]   = {q_q[j-1][k][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[2+j]) begin
        item_q[j] <= item_q[j-1];
        d_q[j]    <= d_q[j-1];
        en_q[j]   <= en_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        rem_q[j]  <= rem_d;
        lo_q[j]   <= lo_d;
        q_q[j]    <= q_d;
      end
    end
  end

  always_comb begin
    out_item_o = item_q[QW];
    if (en_q[QW]) begin
      for (int k = 0; k < NL; k++) begin
        out_item_o.mag[k] = ovf_q[QW][k] ? (MW'(1) << QW) : MW'(q_q[QW][k]);
      end
    end
  end

  property p_rem_below_divisor;
    @(posedge clk_i) disable iff (!rst_ni)
      (v_q[NS-1] && en_q[QW] && !ovf_q[QW][0]) |-> (rem_q[QW][0] < d_q[QW]);
  endproperty
  a_rem_below_divisor: assert property (p_rem_below_divisor)
    else $error("divider remainder not below divisor");

  property p_limit_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni)
      (v_q[NS-1] && en_q[QW] && (USE_POWER == 1'b0)) |-> (ovf_q[QW] == '0);
  endproperty
  a_limit_no_overflow: assert property (p_limit_no_overflow)
    else $error("speed limit quotient overflowed");

  property p_limit_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      (v_q[NS-1] && en_q[QW] && (USE_POWER == 1'b0)) |->
      (q_q[QW][0] <= QW'(cfg_i.max_wheel_speed)) &&
      (q_q[QW][3] <= QW'(cfg_i.max_wheel_speed));
  endproperty
  a_limit_bound: assert property (p_limit_bound)
    else $error("limited wheel speed above the limit");

endmodule

// ===== hdl/omni_wheel_mixer_with_limits.sv =====
// Top level of the four wheel omni mixer with speed and power limits.
// Depends on owm_pkg, owm_regs, owm_kin and owm_scale.
//
// Usage: a command word (velocity, power limit, validity flags) enters on
// the in channel when in_valid_i is high and in_stall_o is low. One word of
// four wheel speeds leaves on the out channel for each command, in order.
// The user must write the configuration registers through the APB-style
// port while no command is in flight; the block itself does not enforce it.
// pready is always high. From acceptance to out_valid_o a word passes seven
// kinematics stages, two scaling units of 35 stages each (two multiply and
// add stages, one setup stage and one divider stage per quotient bit) and
// the output register. Throughput is one word per cycle while the receiver
// does not stall; the per-bit divider stages set the latency.
// Reset empties the pipeline and loads the registers with their reset
// values. When the receiver stalls, results stay in the output register
// and the pipeline keeps taking words until every stage holds one.
module omni_wheel_mixer_with_limits #(
  parameter int FRAC_BITS = owm_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  owm_pkg::owm_in_t          in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output owm_pkg::owm_out_t         out_word_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [owm_pkg::AddrW-1:0] paddr,
  input  logic [owm_pkg::DataW-1:0] pwdata,
  output logic [owm_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int NL = owm_pkg::NumLanes;
  localparam int MW = owm_pkg::MagW;
  localparam int DW = owm_pkg::DataW;
  localparam logic [MW-1:0] NegSat = MW'(1) << (DW - 1);
  localparam logic [MW-1:0] PosSat = NegSat - MW'(1);

  owm_pkg::owm_cfg_t  cfg;
  owm_pkg::owm_item_t kin_item, lim_item, pwr_item;
  logic               kin_valid, kin_stall;
  logic               lim_valid, lim_stall;
  logic               pwr_valid, pwr_stall;

  logic               out_valid_q;
  owm_pkg::owm_out_t  out_word_q, out_word_d;
  logic               out_rdy;

  owm_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owm_kin #(.FRAC_BITS(FRAC_BITS)) u_kin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg),
    .out_valid_o (kin_valid),
    .out_stall_i (kin_stall),
    .out_item_o  (kin_item)
  );

  owm_scale #(.USE_POWER(1'b0)) u_limit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (kin_valid),
    .in_stall_o  (kin_stall),
    .in_item_i   (kin_item),
    .cfg_i       (cfg),
    .out_valid_o (lim_valid),
    .out_stall_i (lim_stall),
    .out_item_o  (lim_item)
  );

  owm_scale #(.USE_POWER(1'b1)) u_power (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lim_valid),
    .in_stall_o  (lim_stall),
    .in_item_i   (lim_item),
    .cfg_i       (cfg),
    .out_valid_o (pwr_valid),
    .out_stall_i (pwr_stall),
    .out_item_o  (pwr_item)
  );

  assign out_rdy     = !out_valid_q || !out_stall_i;
  assign pwr_stall   = !out_rdy;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    logic [NL-1:0][DW-1:0] v;
    logic [MW-1:0]         m;
    v = '0;
    m = '0;
    for (int k = 0; k < NL; k++) begin
      m = pwr_item.mag[k];
      if (pwr_item.pwr_zero) begin
        v[k] = '0;
      end else if (pwr_item.neg[k]) begin
        m    = (m > NegSat) ? NegSat : m;
        v[k] = DW'(-m);
      end else begin
        v[k] = (m > PosSat) ? PosSat[DW-1:0] : m[DW-1:0];
      end
    end
    out_word_d.wheel_speed_a = v[0];
    out_word_d.wheel_speed_b = v[1];
    out_word_d.wheel_speed_c = v[2];
    out_word_d.wheel_speed_d = v[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= pwr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_word_q <= out_word_d;
    end
  end

endmodule
